>>> rtl/tcpwm_pkg.sv
// shared constants, codes and prescaler table for the timer/counter block
package tcpwm_pkg;

    // default counter width
    localparam int COUNTER_WIDTH_DEF = 8;

    // prescaler count width and width of its compare sum
    localparam int PRESCALE_W = 10;
    localparam int DIVISOR_W  = PRESCALE_W + 1;

    // item mode codes (carried on tuser)
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_TICK      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WR_COUNT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WR_COMP   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLR_FLAGS = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FORCE     = 3'd4;

    // flag mask width
    localparam int MASK_W = 2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAVEFORM   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_SEL  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMP_IRQ   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OVF_IRQ    = 3'd4;

    // waveform mode codes
    localparam logic [1:0] WGM_NORMAL = 2'd0;
    localparam logic [1:0] WGM_CTC    = 2'd1;
    localparam logic [1:0] WGM_FPWM   = 2'd2;

    // output mode codes
    localparam logic [1:0] COM_OFF    = 2'd0;
    localparam logic [1:0] COM_TOGGLE = 2'd1;
    localparam logic [1:0] COM_CLEAR  = 2'd2;
    localparam logic [1:0] COM_SET    = 2'd3;

    // clock select: stopped
    localparam logic [2:0] CS_STOP = 3'd0;

    // prescaler divisor for each clock select code
    function automatic logic [DIVISOR_W-1:0] divisor(input logic [2:0] cs);
        logic [DIVISOR_W-1:0] d;
        unique case (cs)
            3'd1:    d = 11'd1;
            3'd2:    d = 11'd8;
            3'd3:    d = 11'd32;
            3'd4:    d = 11'd64;
            3'd5:    d = 11'd128;
            3'd6:    d = 11'd256;
            3'd7:    d = 11'd1024;
            default: d = 11'd0;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/timer_counter_ctc_fast_pwm.sv
// timer/counter with prescaler, clear on compare and fast pwm, stream in and out
// all work is one pass of logic: the result of an accepted word goes straight into the result register
// throughput: one word per cycle while s_tready is high
// a skid entry behind the output register takes one more word while m_tready is low;
// s_tready drops while it is full and rises again once the entry has moved into the output register
// reset: asynchronous, clears configuration, counter, prescaler, compare values, pin and flags
module timer_counter_ctc_fast_pwm #(
    parameter int COUNTER_WIDTH = tcpwm_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [tcpwm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tcpwm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // value, flag_mask
    input  logic [((COUNTER_WIDTH+tcpwm_pkg::MASK_W+7)/8)*8-1:0] s_tdata,
    // mode
    input  logic [tcpwm_pkg::MODE_W-1:0]        s_tuser,
    // result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // count, compare_in_use, wave_out, compare_flag, overflow_flag, irq
    output logic [((2*COUNTER_WIDTH+4+7)/8)*8-1:0] m_tdata
);

    localparam int W     = COUNTER_WIDTH;
    localparam int OUT_W = ((2*COUNTER_WIDTH+4+7)/8)*8;
    localparam int PW    = tcpwm_pkg::PRESCALE_W;
    localparam int DW    = tcpwm_pkg::DIVISOR_W;

    // configuration registers
    logic [1:0] waveform_reg;
    logic [1:0] output_mode_reg;
    logic [2:0] clock_sel_reg;
    logic       comp_irq_en_reg;
    logic       ovf_irq_en_reg;

    // timer state
    logic [PW-1:0] prescale_reg, prescale_next;
    logic [W-1:0]  count_reg, count_next;
    logic [W-1:0]  comp_active_reg, comp_active_next;
    logic [W-1:0]  comp_pending_reg, comp_pending_next;
    logic          wave_reg, wave_next;
    logic          comp_hit_reg, comp_hit_next;
    logic          ovf_hit_reg, ovf_hit_next;

    // result buffer
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [OUT_W-1:0] skid_data_reg;

    logic                        accept;
    logic                        out_free;
    logic [tcpwm_pkg::MODE_W-1:0] item_mode;
    logic [W-1:0]                item_value;
    logic [tcpwm_pkg::MASK_W-1:0] item_mask;
    logic [OUT_W-1:0]            result_word;
    logic                        irq_next;

    // handshake
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // unpack the input word
    assign item_mode  = s_tuser;
    assign item_value = s_tdata[W-1:0];
    assign item_mask  = s_tdata[W+tcpwm_pkg::MASK_W-1:W];

    // next state for one accepted word
    always_comb
    begin
        logic       pwm;
        logic       ctc;
        logic       matched;
        logic       at_max;
        logic [W-1:0] stepped;

        pwm = (waveform_reg == tcpwm_pkg::WGM_FPWM);
        ctc = (waveform_reg == tcpwm_pkg::WGM_CTC);
        matched = (count_reg == comp_active_reg);
        at_max  = (count_reg == {W{1'b1}});
        stepped = at_max ? '0 : count_reg + {{(W-1){1'b0}}, 1'b1};

        prescale_next     = prescale_reg;
        count_next        = count_reg;
        comp_active_next  = comp_active_reg;
        comp_pending_next = comp_pending_reg;
        wave_next         = wave_reg;
        comp_hit_next     = comp_hit_reg;
        ovf_hit_next      = ovf_hit_reg;

        unique case (item_mode)
            tcpwm_pkg::MODE_TICK:
            begin
                if (clock_sel_reg != tcpwm_pkg::CS_STOP)
                begin
                    if ({1'b0, prescale_reg} + {{(DW-1){1'b0}}, 1'b1}
                        >= tcpwm_pkg::divisor(clock_sel_reg))
                    begin
                        prescale_next = '0;
                        // compare match on the count before the step
                        if (matched)
                        begin
                            comp_hit_next = 1'b1;
                            unique case (output_mode_reg)
                                tcpwm_pkg::COM_TOGGLE: wave_next = pwm ? wave_reg : !wave_reg;
                                tcpwm_pkg::COM_CLEAR:  wave_next = 1'b0;
                                tcpwm_pkg::COM_SET:    wave_next = 1'b1;
                                default:               wave_next = wave_reg;
                            endcase
                            if (ctc)
                                stepped = '0;
                        end
                        // wrap to bottom, bottom action wins in pwm
                        if (at_max)
                        begin
                            ovf_hit_next = 1'b1;
                            if (pwm)
                            begin
                                if (output_mode_reg == tcpwm_pkg::COM_CLEAR)
                                    wave_next = 1'b1;
                                else if (output_mode_reg == tcpwm_pkg::COM_SET)
                                    wave_next = 1'b0;
                                comp_active_next = comp_pending_reg;
                            end
                        end
                        count_next = stepped;
                    end
                    else
                    begin
                        prescale_next = prescale_reg + {{(PW-1){1'b0}}, 1'b1};
                    end
                end
            end
            tcpwm_pkg::MODE_WR_COUNT:
            begin
                count_next = item_value;
            end
            tcpwm_pkg::MODE_WR_COMP:
            begin
                comp_pending_next = item_value;
                if (!pwm)
                    comp_active_next = item_value;
            end
            tcpwm_pkg::MODE_CLR_FLAGS:
            begin
                if (item_mask[0])
                    comp_hit_next = 1'b0;
                if (item_mask[1])
                    ovf_hit_next = 1'b0;
            end
            tcpwm_pkg::MODE_FORCE:
            begin
                if (!pwm)
                begin
                    unique case (output_mode_reg)
                        tcpwm_pkg::COM_TOGGLE: wave_next = !wave_reg;
                        tcpwm_pkg::COM_CLEAR:  wave_next = 1'b0;
                        tcpwm_pkg::COM_SET:    wave_next = 1'b1;
                        default:               wave_next = wave_reg;
                    endcase
                end
            end
            default:
            begin
                prescale_next = prescale_reg;
            end
        endcase
    end

    // pack the result word
    assign irq_next = (comp_hit_next && comp_irq_en_reg) || (ovf_hit_next && ovf_irq_en_reg);

    always_comb
    begin
        result_word = '0;
        result_word[W-1:0]     = count_next;
        result_word[2*W-1:W]   = comp_active_next;
        result_word[2*W]       = wave_next;
        result_word[2*W+1]     = comp_hit_next;
        result_word[2*W+2]     = ovf_hit_next;
        result_word[2*W+3]     = irq_next;
    end

    // configuration and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg     <= '0;
            output_mode_reg  <= '0;
            clock_sel_reg    <= '0;
            comp_irq_en_reg  <= 1'b0;
            ovf_irq_en_reg   <= 1'b0;
            prescale_reg     <= '0;
            count_reg        <= '0;
            comp_active_reg  <= '0;
            comp_pending_reg <= '0;
            wave_reg         <= 1'b0;
            comp_hit_reg     <= 1'b0;
            ovf_hit_reg      <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tcpwm_pkg::CFG_WAVEFORM:
                begin
                    waveform_reg <= cfg_wdata[1:0];
                    if (cfg_wdata[1:0] != tcpwm_pkg::WGM_FPWM)
                        comp_active_reg <= comp_pending_reg;
                end
                tcpwm_pkg::CFG_OUTPUT:    output_mode_reg <= cfg_wdata[1:0];
                tcpwm_pkg::CFG_CLOCK_SEL: clock_sel_reg   <= cfg_wdata;
                tcpwm_pkg::CFG_COMP_IRQ:  comp_irq_en_reg <= cfg_wdata[0];
                tcpwm_pkg::CFG_OVF_IRQ:   ovf_irq_en_reg  <= cfg_wdata[0];
                default:                  waveform_reg    <= waveform_reg;
            endcase
        end
        else if (accept)
        begin
            prescale_reg     <= prescale_next;
            count_reg        <= count_next;
            comp_active_reg  <= comp_active_next;
            comp_pending_reg <= comp_pending_next;
            wave_reg         <= wave_next;
            comp_hit_reg     <= comp_hit_next;
            ovf_hit_reg      <= ovf_hit_next;
        end
    end

    // result buffer valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (accept)
                out_data_reg <= result_word;
        end
        else if (accept)
        begin
            skid_data_reg <= result_word;
        end
    end

endmodule
